@@ rtl/core/delta_patch_applier_defines.svh @@
// Assertion macros for the delta patch applier.
// Both macros assume the enclosing module has i_clk and i_rst_n.
`ifndef DELTA_PATCH_APPLIER_DEFINES_SVH
`define DELTA_PATCH_APPLIER_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define DPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define DPA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define DPA_ASSERT(lbl, prop, msg)
`define DPA_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/core/dpa_pkg.sv @@
`default_nettype none
package dpa_pkg;

    // largest frame the block handles; frame_size above it is clamped
    localparam int FRAME_MAX = 65536;
    localparam int FS_W      = 17;
    localparam logic [FS_W-1:0] FS_CAP =
        (FRAME_MAX > (2 ** FS_W) - 1) ? {FS_W{1'b1}} : FS_W'(FRAME_MAX);

    // record header: 32-bit skip then 32-bit copy, little endian
    localparam int HDR_BYTES = 2 * 4;
    localparam logic [2:0] HDR_LAST = 3'(HDR_BYTES - 1);

    // depth of the queue between front and back
    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COPY,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNC     = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    // result kinds on the output tuser
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // work for the back end produced by one patch byte
    typedef struct packed {
        logic        has_write;
        logic [15:0] offset;
        logic [7:0]  value;
        logic        has_status;
        t_status     status;
    } t_entry;

endpackage
`default_nettype wire

@@ rtl/core/dpa_fifo.sv @@
`default_nettype none
`include "delta_patch_applier_defines.svh"
module dpa_fifo
    import dpa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output logic        o_full,
    output logic        o_empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(QDEPTH - 1);

    t_entry           r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_TOP) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_TOP) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);

    `DPA_NEVER(a_q_overflow, i_push && o_full, "queue written while full")
    `DPA_NEVER(a_q_underflow, i_pop && o_empty, "queue read while empty")

endmodule
`default_nettype wire

@@ rtl/core/dpa_front.sv @@
`default_nettype none
`include "delta_patch_applier_defines.svh"
module dpa_front
    import dpa_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [FS_W-1:0] i_cfg_data,
    input  wire logic            i_in_valid,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_in_last,
    output logic                 o_in_ready,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output t_entry               o_entry
);

    logic [FS_W-1:0] r_frame_size;
    t_phase          r_phase, n_phase;
    logic [2:0]      r_hdr_idx, n_hdr_idx;
    logic [FS_W-1:0] r_skip, n_skip;
    logic            r_skip_big, n_skip_big;
    logic [FS_W-1:0] r_copy, n_copy;
    logic            r_copy_big, n_copy_big;
    logic [FS_W-1:0] r_pos, n_pos;

    logic            accept;
    logic [FS_W-1:0] fs;
    logic [FS_W+1:0] run_end;
    logic [FS_W-1:0] pos_skipped;
    logic [FS_W-1:0] pos_inc;
    logic            run_over;
    t_entry          ent;

    // frame size register; taken whenever written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= '0;
        end else if (i_cfg_valid) begin
            r_frame_size <= i_cfg_data;
        end
    end

    assign fs         = (r_frame_size > FS_CAP) ? FS_CAP : r_frame_size;
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // high parts of skip and copy only matter as "too big" flags
    assign run_end     = (FS_W+2)'(r_pos) + (FS_W+2)'(r_skip) + (FS_W+2)'(r_copy);
    assign run_over    = r_skip_big || r_copy_big || (i_in_byte != 8'd0)
                         || (run_end > (FS_W+2)'(fs));
    assign pos_skipped = r_pos + r_skip;
    assign pos_inc     = r_pos + 1'b1;

    // byte classification and record state
    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_skip     = r_skip;
        n_skip_big = r_skip_big;
        n_copy     = r_copy;
        n_copy_big = r_copy_big;
        n_pos      = r_pos;
        ent        = '0;
        if (accept) begin
            unique case (r_phase) inside
                PH_HEADER: begin
                    if (r_pos >= fs) begin
                        n_phase = PH_DONE;
                    end else if (r_hdr_idx == HDR_LAST) begin
                        // last copy byte: its value only feeds the overflow check
                        n_hdr_idx = '0;
                        if (run_over) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_pos  = pos_skipped;
                            n_skip = '0;
                            if (r_copy != '0) begin
                                n_phase = PH_COPY;
                            end else if (pos_skipped >= fs) begin
                                n_phase = PH_DONE;
                            end
                        end
                    end else begin
                        n_hdr_idx = r_hdr_idx + 1'b1;
                        unique case (r_hdr_idx)
                            3'd0: begin
                                n_skip     = FS_W'(i_in_byte);
                                n_skip_big = 1'b0;
                            end
                            3'd1: n_skip[15:8] = i_in_byte;
                            3'd2: begin
                                n_skip[16] = i_in_byte[0];
                                n_skip_big = r_skip_big || (i_in_byte[7:1] != 7'd0);
                            end
                            3'd3: n_skip_big = r_skip_big || (i_in_byte != 8'd0);
                            3'd4: begin
                                n_copy     = FS_W'(i_in_byte);
                                n_copy_big = 1'b0;
                            end
                            3'd5: n_copy[15:8] = i_in_byte;
                            3'd6: begin
                                n_copy[16] = i_in_byte[0];
                                n_copy_big = r_copy_big || (i_in_byte[7:1] != 7'd0);
                            end
                            default: n_copy_big = r_copy_big;
                        endcase
                    end
                end
                PH_COPY: begin
                    ent.has_write = 1'b1;
                    ent.offset    = r_pos[15:0];
                    ent.value     = i_in_byte;
                    n_pos         = pos_inc;
                    n_copy        = r_copy - 1'b1;
                    if (r_copy == FS_W'(1)) begin
                        n_phase = (pos_inc >= fs) ? PH_DONE : PH_HEADER;
                    end
                end
                PH_DONE, PH_ERROR: begin
                    // bytes ignored until the end of the patch
                end
            endcase

            // final status, then back to the start of a frame
            if (i_in_last) begin
                ent.has_status = 1'b1;
                if (n_phase == PH_ERROR || n_phase == PH_COPY) begin
                    ent.status = ST_MALFORMED;
                end else if (n_phase == PH_DONE || n_pos >= fs) begin
                    ent.status = ST_OK;
                end else begin
                    ent.status = ST_TRUNC;
                end
                n_phase    = PH_HEADER;
                n_hdr_idx  = '0;
                n_skip     = '0;
                n_skip_big = 1'b0;
                n_copy     = '0;
                n_copy_big = 1'b0;
                n_pos      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_idx  <= '0;
            r_skip     <= '0;
            r_skip_big <= 1'b0;
            r_copy     <= '0;
            r_copy_big <= 1'b0;
            r_pos      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_skip     <= n_skip;
            r_skip_big <= n_skip_big;
            r_copy     <= n_copy;
            r_copy_big <= n_copy_big;
            r_pos      <= n_pos;
        end
    end

    assign o_push  = accept && (ent.has_write || ent.has_status);
    assign o_entry = ent;

    // header bytes are only counted while collecting a header
    `DPA_ASSERT(a_idx_in_header, (r_phase != PH_HEADER) |-> (r_hdr_idx == 3'd0),
        "header index left non-zero outside header phase")
    // a literal byte is only ever written inside the frame
    `DPA_NEVER(a_write_in_frame, ent.has_write && accept && (r_pos >= fs),
        "write emitted past frame end")

endmodule
`default_nettype wire

@@ rtl/core/dpa_back.sv @@
`default_nettype none
`include "delta_patch_applier_defines.svh"
module dpa_back
    import dpa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_head,
    input  wire logic   i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic        o_kind,
    output logic [15:0] o_offset,
    output logic [7:0]  o_value,
    output t_status     o_status,
    output logic        o_last
);

    logic        r_out_valid, n_out_valid;
    logic        r_out_kind, n_out_kind;
    logic [15:0] r_out_offset, n_out_offset;
    logic [7:0]  r_out_value, n_out_value;
    t_status     r_out_status, n_out_status;
    logic        r_out_last, n_out_last;
    // status still owed after a write from the same byte
    logic        r_pend, n_pend;
    t_status     r_pend_status, n_pend_status;

    logic        load_en;

    assign load_en = !r_out_valid || i_ready;
    assign o_pop   = load_en && !r_pend && !i_empty;

    // output register load: pending status first, then next queue entry
    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_kind    = r_out_kind;
        n_out_offset  = r_out_offset;
        n_out_value   = r_out_value;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;
        n_pend        = r_pend;
        n_pend_status = r_pend_status;
        if (load_en) begin
            if (r_pend) begin
                n_out_valid  = 1'b1;
                n_out_kind   = KIND_STATUS;
                n_out_offset = '0;
                n_out_value  = '0;
                n_out_status = r_pend_status;
                n_out_last   = 1'b1;
                n_pend       = 1'b0;
            end else if (!i_empty) begin
                n_out_valid = 1'b1;
                if (i_head.has_write) begin
                    n_out_kind    = KIND_WRITE;
                    n_out_offset  = i_head.offset;
                    n_out_value   = i_head.value;
                    n_out_status  = ST_OK;
                    n_out_last    = !i_head.has_status;
                    n_pend        = i_head.has_status;
                    n_pend_status = i_head.status;
                end else begin
                    n_out_kind   = KIND_STATUS;
                    n_out_offset = '0;
                    n_out_value  = '0;
                    n_out_status = i_head.status;
                    n_out_last   = 1'b1;
                end
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind    <= n_out_kind;
        r_out_offset  <= n_out_offset;
        r_out_value   <= n_out_value;
        r_out_status  <= n_out_status;
        r_out_last    <= n_out_last;
        r_pend_status <= n_pend_status;
    end

    assign o_valid  = r_out_valid;
    assign o_kind   = r_out_kind;
    assign o_offset = r_out_offset;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

    // an owed status always sits behind a write still on the output
    `DPA_ASSERT(a_pend_behind_write,
        r_pend |-> (r_out_valid && !r_out_last && (r_out_kind == KIND_WRITE)),
        "pending status without its write on the output")

endmodule
`default_nettype wire

@@ rtl/core/delta_patch_applier.sv @@
`default_nettype none
// Delta patch applier. Takes a skip/copy patch one byte per transaction on the
// s_axis side (tdata[7:0] the byte, tlast the final byte of a patch) and turns
// every literal byte into a frame write (m_axis_tuser = 0) carrying offset and
// value; the final byte also yields a status result (m_axis_tuser = 1) with
// ok, truncated or malformed, and m_axis_tlast marks the last result of each
// input byte. One patch byte is accepted per cycle: the header and run
// bookkeeping is a single compare-and-add step, and a four-entry queue sits
// between the byte classifier and the output register. The output register
// issues one result per cycle while tready is high, so a final byte with a
// literal yields a write and then a status; sustained input stalls only when
// downstream holds tready low long enough to fill the queue. The frame size
// must be written via cfg between patches (the block does not enforce it); it
// is clamped to 65536, zero ignores every byte. No clearing pass follows reset.
module delta_patch_applier
    import dpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: frame_size
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [16:0] i_cfg_data,
    // patch byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] patch_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] offset, [23:16] value,
                                             // [25:24] status, [31:26] zero
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast    // end_of_run
);

    t_entry      push_entry;
    t_entry      head_entry;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    logic [15:0] out_offset;
    logic [7:0]  out_value;
    t_status     out_status;

    assign o_cfg_ready = 1'b1;

    // byte classifier and record tracking
    dpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (s_axis_tvalid),
        .i_in_byte  (s_axis_tdata),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_entry    (push_entry)
    );

    // decoupling queue
    dpa_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_entry(push_entry),
        .i_pop  (q_pop),
        .o_head (head_entry),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    // result sequencing and output register
    dpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_entry),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_offset(out_offset),
        .o_value (out_value),
        .o_status(out_status),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_status, out_value, out_offset};

endmodule
`default_nettype wire
